// ===== rtl/pid_speed_and_gap_follower_unit_defines.svh =====
// assertion macros shared by the pid speed and gap follower rtl
`ifndef PID_SPEED_AND_GAP_FOLLOWER_UNIT_DEFINES_SVH
`define PID_SPEED_AND_GAP_FOLLOWER_UNIT_DEFINES_SVH

// same-cycle implication check
`define PSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid follower check failed");

// next-cycle implication check
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid follower check failed");

`endif

// ===== rtl/psgf_pkg.sv =====
// types and constants of the pid speed and gap follower
package psgf_pkg;

    // fixed field widths
    localparam int VALUE_W   = 32;
    localparam int GAIN_W    = 18;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 5;
    localparam int IDX_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_GAP = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_SPD  = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_POS  = 3'd5;

    // register reset values
    localparam logic signed [GAIN_W-1:0]  GAIN_P_RST     = 18'sd6554;
    localparam logic signed [GAIN_W-1:0]  GAIN_I_RST     = 18'sd655;
    localparam logic signed [GAIN_W-1:0]  GAIN_D_RST     = 18'sd655;
    localparam logic signed [VALUE_W-1:0] TARGET_GAP_RST = 32'sd655360;
    localparam logic signed [VALUE_W-1:0] START_SPD_RST  = 32'sd0;
    localparam logic signed [VALUE_W-1:0] START_POS_RST  = 32'sd655360;

    // input beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] leader_speed;
        logic signed [VALUE_W-1:0] leader_position;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] new_speed;
        logic signed [VALUE_W-1:0] new_position;
        logic                      clipped;
    } t_out_beat;

    // saturated value with its clip flag
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      clip;
    } t_sat_val;

endpackage

// ===== rtl/pid_speed_and_gap_follower_unit.sv =====
// pid speed and gap follower: top level with apb register port
//
// Takes one leader beat (speed, position, signed Q16.16) per clock unless the
// output stalls, and returns one result beat per input beat: the follower's
// new speed after a PID step on the speed error, its new position after a gap
// correction, and a flag set when any difference or sum saturated. Each beat
// passes the input register, then the result register; the loop through the
// own speed, position, error sum and last error registers holds no further
// register. Gains are signed Q2.16 in registers 0..2, the target gap in
// register 3. Writing register 4 (start speed) or 5 (start position) reloads
// the own speed or position and clears the error sum and last error if no step
// is taken. Registers sit at byte address 4*index on apb; pready is always high.
`include "pid_speed_and_gap_follower_unit_defines.svh"

module pid_speed_and_gap_follower_unit
    import psgf_pkg::*;
#(
    parameter int ACCUM_WIDTH = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in_data,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int XW  = (ACCUM_WIDTH > VALUE_W) ? ACCUM_WIDTH : VALUE_W;
    localparam int SPW = GAIN_W + XW + 3;
    localparam int PSW = GAIN_W + VALUE_W + 3;
    localparam logic signed [SPW-1:0] SPD_HALF = SPW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PSW-1:0] POS_HALF = PSW'(1) << (FRAC_BITS - 1);

    // registers
    logic                          r_in_valid;
    t_in_beat                      r_in;
    logic                          r_out_valid;
    t_out_beat                     r_out;
    logic signed [GAIN_W-1:0]      r_gain_p;
    logic signed [GAIN_W-1:0]      r_gain_i;
    logic signed [GAIN_W-1:0]      r_gain_d;
    logic signed [VALUE_W-1:0]     r_target_gap;
    logic signed [VALUE_W-1:0]     r_start_speed;
    logic signed [VALUE_W-1:0]     r_start_position;
    logic signed [VALUE_W-1:0]     r_own_speed;
    logic signed [VALUE_W-1:0]     r_own_position;
    logic signed [ACCUM_WIDTH-1:0] r_error_sum;
    logic signed [VALUE_W-1:0]     r_last_error;

    // next values
    logic signed [VALUE_W-1:0]     n_own_speed;
    logic signed [VALUE_W-1:0]     n_own_position;
    logic signed [ACCUM_WIDTH-1:0] n_error_sum;
    t_out_beat                     n_out;

    // datapath
    logic                          step_go;
    logic                          cfg_wr;
    logic [IDX_W-1:0]              cfg_idx;
    t_sat_val                      e_sat;
    t_sat_val                      d_sat;
    t_sat_val                      gap_sat;
    t_sat_val                      gerr_sat;
    logic signed [XW:0]            es_sum;
    logic                          es_clip;
    logic signed [GAIN_W+VALUE_W-1:0]     prod_p;
    logic signed [GAIN_W+ACCUM_WIDTH-1:0] prod_i;
    logic signed [GAIN_W+VALUE_W-1:0]     prod_d;
    logic signed [SPW-1:0]         spd_acc;
    logic signed [SPW-1:0]         spd_total;
    logic                          spd_clip;
    logic signed [GAIN_W:0]        neg_gain_p;
    logic signed [GAIN_W+VALUE_W:0] prod_g;
    logic signed [PSW-1:0]         pos_acc;
    logic signed [PSW-1:0]         pos_total;
    logic                          pos_clip;

    // saturate a one-bit-wider difference to the value width
    function automatic t_sat_val sat_one(input logic signed [VALUE_W:0] s);
        t_sat_val res;
        res.clip  = s[VALUE_W] != s[VALUE_W-1];
        res.value = res.clip ? {s[VALUE_W], {(VALUE_W-1){~s[VALUE_W]}}} : s[VALUE_W-1:0];
        return res;
    endfunction

    // handshake
    assign step_go     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // register port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    // speed error, error sum and derivative
    assign e_sat  = sat_one((VALUE_W+1)'(r_in.leader_speed) - (VALUE_W+1)'(r_own_speed));
    assign es_sum = (XW+1)'(r_error_sum) + (XW+1)'(e_sat.value);
    assign es_clip = !((&es_sum[XW:ACCUM_WIDTH-1]) || !(|es_sum[XW:ACCUM_WIDTH-1]));
    assign n_error_sum = es_clip ? {es_sum[XW], {(ACCUM_WIDTH-1){~es_sum[XW]}}}
                                 : es_sum[ACCUM_WIDTH-1:0];
    assign d_sat  = sat_one((VALUE_W+1)'(e_sat.value) - (VALUE_W+1)'(r_last_error));

    // pid products, rounded half up and added to the speed
    assign prod_p    = r_gain_p * e_sat.value;
    assign prod_i    = r_gain_i * n_error_sum;
    assign prod_d    = r_gain_d * d_sat.value;
    assign spd_acc   = SPW'(prod_p) + SPW'(prod_i) + SPW'(prod_d) + SPD_HALF;
    assign spd_total = (spd_acc >>> FRAC_BITS) + SPW'(r_own_speed);
    assign spd_clip  = !((&spd_total[SPW-1:VALUE_W-1]) || !(|spd_total[SPW-1:VALUE_W-1]));
    assign n_own_speed = spd_clip ? {spd_total[SPW-1], {(VALUE_W-1){~spd_total[SPW-1]}}}
                                  : spd_total[VALUE_W-1:0];

    // gap error and position correction
    assign gap_sat  = sat_one((VALUE_W+1)'(r_in.leader_position) - (VALUE_W+1)'(r_own_position));
    assign gerr_sat = sat_one((VALUE_W+1)'(r_target_gap) - (VALUE_W+1)'(gap_sat.value));
    assign neg_gain_p = -((GAIN_W+1)'(r_gain_p));
    assign prod_g     = neg_gain_p * gerr_sat.value;
    assign pos_acc    = PSW'(prod_g) + POS_HALF;
    assign pos_total  = (pos_acc >>> FRAC_BITS) + PSW'(r_own_position);
    assign pos_clip   = !((&pos_total[PSW-1:VALUE_W-1]) || !(|pos_total[PSW-1:VALUE_W-1]));
    assign n_own_position = pos_clip ? {pos_total[PSW-1], {(VALUE_W-1){~pos_total[PSW-1]}}}
                                     : pos_total[VALUE_W-1:0];

    // result beat
    always_comb begin
        n_out.new_speed    = n_own_speed;
        n_out.new_position = n_own_position;
        n_out.clipped      = e_sat.clip | es_clip | d_sat.clip | spd_clip
                           | gap_sat.clip | gerr_sat.clip | pos_clip;
    end

    // register read mux
    always_comb begin
        case (cfg_idx)
            REG_GAIN_P:     prdata = DATA_W'(r_gain_p);
            REG_GAIN_I:     prdata = DATA_W'(r_gain_i);
            REG_GAIN_D:     prdata = DATA_W'(r_gain_d);
            REG_TARGET_GAP: prdata = DATA_W'(r_target_gap);
            REG_START_SPD:  prdata = DATA_W'(r_start_speed);
            REG_START_POS:  prdata = DATA_W'(r_start_position);
            default:        prdata = '0;
        endcase
    end

    // control, configuration and follower state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_gain_p         <= GAIN_P_RST;
            r_gain_i         <= GAIN_I_RST;
            r_gain_d         <= GAIN_D_RST;
            r_target_gap     <= TARGET_GAP_RST;
            r_start_speed    <= START_SPD_RST;
            r_start_position <= START_POS_RST;
            r_own_speed      <= START_SPD_RST;
            r_own_position   <= START_POS_RST;
            r_error_sum      <= '0;
            r_last_error     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_GAIN_P:     r_gain_p         <= pwdata[GAIN_W-1:0];
                    REG_GAIN_I:     r_gain_i         <= pwdata[GAIN_W-1:0];
                    REG_GAIN_D:     r_gain_d         <= pwdata[GAIN_W-1:0];
                    REG_TARGET_GAP: r_target_gap     <= pwdata[VALUE_W-1:0];
                    REG_START_SPD:  r_start_speed    <= pwdata[VALUE_W-1:0];
                    REG_START_POS:  r_start_position <= pwdata[VALUE_W-1:0];
                    default: ;
                endcase
            end
            // state update from a step, else a start value reload
            if (step_go) begin
                r_own_speed    <= n_own_speed;
                r_own_position <= n_own_position;
                r_error_sum    <= n_error_sum;
                r_last_error   <= e_sat.value;
            end else if (cfg_wr) begin
                case (cfg_idx)
                    REG_START_SPD: begin
                        r_own_speed  <= pwdata[VALUE_W-1:0];
                        r_error_sum  <= '0;
                        r_last_error <= '0;
                    end
                    REG_START_POS: begin
                        r_own_position <= pwdata[VALUE_W-1:0];
                        r_error_sum    <= '0;
                        r_last_error   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (step_go) begin
            r_out <= n_out;
        end
    end

    // checks
    `PSG_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, r_in_valid)
    `PSG_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step_go, r_out_valid)
    `PSG_ASSERT_NOW(a_result_matches_state, i_clk, i_rst_n, r_out_valid && $past(step_go), (r_out.new_speed == r_own_speed) && (r_out.new_position == r_own_position))
    `PSG_ASSERT_NEXT(a_start_clears_errors, i_clk, i_rst_n, cfg_wr && !step_go && (cfg_idx == REG_START_SPD || cfg_idx == REG_START_POS), (r_error_sum == '0) && (r_last_error == '0))

endmodule
